// ----- hdl/assert_macros.svh -----
// Assertion macros for the dedup table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/htdt_pkg.sv -----
// Types and constants shared by the dedup table modules
`default_nettype none
package htdt_pkg;
  localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
  localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
  localparam logic [63:0] FIB_MULT  = 64'd11400714819323198486;
  localparam logic [63:0] FNV_SEED  = 64'd11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_MISSING  = 2'd3;

  // byte_0 sits in the low bits so the packed tuple reads as a little-endian key
  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_7;
    logic [7:0] byte_6;
    logic [7:0] byte_5;
    logic [7:0] byte_4;
    logic [7:0] byte_3;
    logic [7:0] byte_2;
    logic [7:0] byte_1;
    logic [7:0] byte_0;
  } htdt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] first_seen;
    logic [10:0] distinct_total;
  } htdt_result_t;

  typedef enum logic [1:0] {HS_IDLE, HS_MUL, HS_FIB, HS_DONE} hash_state_t;
  typedef enum logic [2:0] {PS_IDLE, PS_READ, PS_WAIT, PS_CHECK, PS_OUT} probe_state_t;
endpackage
`default_nettype wire

// ----- hdl/htdt_if.sv -----
// Valid/ready channel interface
`default_nettype none
interface htdt_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/htdt_mul64.sv -----
// 64x64 low-half multiplier, three 32x32 partial products over cycles
`default_nettype none
module htdt_mul64 import htdt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      prod
);
  logic [2:0]  step_r;
  logic [63:0] a_r, b_r, acc_r;
  logic [63:0] pp;
  logic [31:0] x, y;

  always_comb begin
    x = a_r[31:0];
    y = b_r[31:0];
    case (step_r)
      3'd1: begin x = a_r[31:0];  y = b_r[31:0];  end
      3'd2: begin x = a_r[63:32]; y = b_r[31:0];  end
      3'd3: begin x = a_r[31:0];  y = b_r[63:32]; end
      default: ;
    endcase
    pp = {32'd0, x} * {32'd0, y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else if (start) begin
      step_r <= 3'd1;
    end else if (step_r != 3'd0) begin
      step_r <= (step_r == 3'd3) ? 3'd0 : step_r + 3'd1;
    end
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= 64'd0;
    end else if (step_r == 3'd1) begin
      acc_r <= pp;
    end else if (step_r != 3'd0) begin
      acc_r <= acc_r + {pp[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) done <= 1'b0;
    else done <= (step_r == 3'd3);
  end
  assign prod = acc_r;
endmodule
`default_nettype wire

// ----- hdl/htdt_front.sv -----
// Front end: accepts tuples, hashes them to a home slot, queues them
`default_nettype none
module htdt_front import htdt_pkg::*; #(
  parameter int INDEX_BITS = 10,
  parameter int TUPLE_LEN  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_opcode,
  input  wire logic [63:0]           in_key,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic                       q_opcode,
  output logic [63:0]                q_key,
  output logic [INDEX_BITS-1:0]      q_home
);
  localparam logic [63:0] KEY_MASK = ~64'd0 >> (8 * (8 - TUPLE_LEN));
  localparam int QW = 1 + 64 + INDEX_BITS;

  hash_state_t state_r, state_nxt;
  logic [63:0] h_r, key_r;
  logic        op_r;
  logic [3:0]  byte_r;
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;
  logic [7:0]  cur_byte;

  // two-entry queue toward the probe engine
  logic [QW-1:0] q_mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          push, pop;

  assign cur_byte = key_r[8*byte_r[2:0] +: 8];
  assign in_ready = (state_r == HS_IDLE);

  htdt_mul64 u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      HS_IDLE: if (in_valid) state_nxt = HS_MUL;
      HS_MUL:  if (mul_done && byte_r == 4'(TUPLE_LEN - 1)) state_nxt = HS_FIB;
      HS_FIB:  if (mul_done) state_nxt = HS_DONE;
      HS_DONE: if (cnt_r != 2'd2) state_nxt = HS_IDLE;
      default: state_nxt = HS_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = h_r ^ {56'd0, cur_byte};
    mul_b = FNV_PRIME;
    push = 1'b0;
    case (state_r)
      HS_IDLE: mul_start = in_valid;
      HS_MUL: begin
        if (mul_done) begin
          mul_start = 1'b1;
          if (byte_r == 4'(TUPLE_LEN - 1)) begin
            mul_a = mul_p;
            mul_b = FIB_MULT;
          end else begin
            mul_a = mul_p ^ {56'd0, key_r[8*(byte_r[2:0]+3'd1) +: 8]};
          end
        end
      end
      HS_DONE: push = (cnt_r != 2'd2);
      default: ;
    endcase
    if (state_r == HS_IDLE) mul_a = (FNV_BASIS ^ FNV_SEED) ^ {56'd0, in_key[7:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      byte_r  <= 4'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == HS_IDLE) byte_r <= 4'd0;
      else if (state_r == HS_MUL && mul_done) byte_r <= byte_r + 4'd1;
    end
    if (state_r == HS_IDLE && in_valid) begin
      key_r <= in_key & KEY_MASK;
      op_r  <= in_opcode;
    end
    if (state_r == HS_MUL && mul_done) h_r <= mul_p;
    if (state_r == HS_FIB && mul_done) h_r <= mul_p;
  end

  assign pop = q_valid && q_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_mem_r[wp_r] <= {op_r, key_r, h_r[63 -: INDEX_BITS]};
  end

  assign q_valid = (cnt_r != 2'd0);
  assign {q_opcode, q_key, q_home} = q_mem_r[rp_r];

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= 2'd2)
  `ASSERT_IMPL(a_no_push_full, push, cnt_r != 2'd2)
  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == HS_MUL)
endmodule
`default_nettype wire

// ----- hdl/htdt_back.sv -----
// Back end: linear probe over the slot table, insert and result register
`default_nettype none
module htdt_back import htdt_pkg::*; #(
  parameter int INDEX_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  input  wire logic                  q_opcode,
  input  wire logic [63:0]           q_key,
  input  wire logic [INDEX_BITS-1:0] q_home,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output htdt_result_t               res
);
  localparam int DEPTH = 1 << INDEX_BITS;

  probe_state_t state_r, state_nxt;
  logic [63:0]  tup_mem [DEPTH];
  logic [31:0]  fs_mem [DEPTH];
  logic         vld_mem [DEPTH];
  logic [63:0]  rd_tup_r;
  logic [31:0]  rd_fs_r;
  logic         rd_vld_r;
  logic [INDEX_BITS-1:0] idx_r, home_r;
  logic [INDEX_BITS:0]   steps_r;
  logic [63:0]  key_r;
  logic         op_r;
  logic [10:0]  distinct_r;
  logic [31:0]  ins_cnt_r;
  logic         hit, empty, wrapped, wr_en;
  logic [INDEX_BITS-1:0] clr_idx_r;
  logic         clearing_r;

  assign hit     = rd_vld_r && (rd_tup_r == key_r);
  assign empty   = !rd_vld_r;
  assign wrapped = (steps_r == (INDEX_BITS+1)'(DEPTH - 1));
  assign wr_en   = (state_r == PS_CHECK) && empty && (op_r == OP_INSERT);
  assign q_ready = (state_r == PS_IDLE) && !clearing_r;
  assign res_valid = (state_r == PS_OUT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PS_IDLE:  if (q_valid && q_ready) state_nxt = PS_READ;
      PS_READ:  state_nxt = PS_WAIT;
      PS_WAIT:  state_nxt = PS_CHECK;
      PS_CHECK: state_nxt = (hit || empty || wrapped) ? PS_OUT : PS_READ;
      PS_OUT:   if (res_ready) state_nxt = PS_IDLE;
      default:  state_nxt = PS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == PS_READ) begin
      rd_tup_r <= tup_mem[idx_r];
      rd_fs_r  <= fs_mem[idx_r];
    end
    if (wr_en) begin
      tup_mem[idx_r] <= key_r;
      fs_mem[idx_r]  <= ins_cnt_r;
    end
  end

  // valid marks are swept clear one slot per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + INDEX_BITS'(1);
      if (clr_idx_r == INDEX_BITS'(DEPTH - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      vld_mem[clr_idx_r] <= 1'b0;
    end else if (wr_en) begin
      vld_mem[idx_r] <= 1'b1;
    end
    if (state_r == PS_READ) rd_vld_r <= vld_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= PS_IDLE;
      distinct_r <= 11'd0;
      ins_cnt_r  <= 32'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == PS_CHECK && state_nxt == PS_OUT) begin
        if (op_r == OP_INSERT) ins_cnt_r <= ins_cnt_r + 32'd1;
        if (wr_en) distinct_r <= distinct_r + 11'd1;
      end
    end
    case (state_r)
      PS_IDLE: begin
        if (q_valid && q_ready) begin
          key_r   <= q_key;
          op_r    <= q_opcode;
          idx_r   <= q_home;
          home_r  <= q_home;
          steps_r <= '0;
        end
      end
      PS_CHECK: begin
        if (hit) begin
          res.status     <= ST_PRESENT;
          res.slot       <= 10'(idx_r);
          res.first_seen <= rd_fs_r;
        end else if (empty) begin
          res.slot       <= 10'(idx_r);
          res.status     <= (op_r == OP_INSERT) ? ST_INSERTED : ST_MISSING;
          res.first_seen <= (op_r == OP_INSERT) ? ins_cnt_r : 32'd0;
        end else if (wrapped) begin
          res.slot       <= 10'(home_r);
          res.status     <= (op_r == OP_INSERT) ? ST_FULL : ST_MISSING;
          res.first_seen <= 32'd0;
        end else begin
          idx_r   <= idx_r + INDEX_BITS'(1);
          steps_r <= steps_r + (INDEX_BITS+1)'(1);
        end
        res.distinct_total <= wr_en ? distinct_r + 11'd1 : distinct_r;
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_write_counts, wr_en, distinct_r == $past(distinct_r) + 11'd1)
  `ASSERT_IMPL(a_no_write_query, wr_en, op_r == OP_INSERT)
  `ASSERT_NEXT(a_out_holds, res_valid && !res_ready, res_valid && $stable(res))
endmodule
`default_nettype wire

// ----- hdl/hashed_tuple_dedup_table.sv -----
// Top level of the hashed tuple dedup table
// Tuple dedup table: each transaction (opcode plus eight bytes) has its first
// TUPLE_LEN key bytes hashed (the opcode is not hashed) with FNV-1a from a seeded
// basis and a Fibonacci multiply into a home slot of 2^INDEX_BITS, then linearly
// probed for a match or an empty slot. The front end runs the TUPLE_LEN+1
// multiplies on one 64x64 multiplier built from three 32x32 partial products.
// A two-entry queue lets the next tuple hash while the back end probes; each
// probe step passes through the READ, WAIT and CHECK states for the registered
// table read. Sustained rate is set by the hash multiplier when probes are short.
// After reset the back end clears all 2^INDEX_BITS valid marks (1024 by default)
// before its first lookup; the front end keeps hashing and queueing meanwhile
// until its two-entry queue is full.
`default_nettype none
module hashed_tuple_dedup_table import htdt_pkg::*; #(
  parameter int INDEX_BITS = 10,
  parameter int TUPLE_LEN  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  htdt_if.sink      in_ch,
  htdt_if.source    out_ch
);
  logic                  q_valid, q_ready, q_opcode;
  logic [63:0]           q_key;
  logic [INDEX_BITS-1:0] q_home;

  htdt_front #(.INDEX_BITS(INDEX_BITS), .TUPLE_LEN(TUPLE_LEN)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_opcode(in_ch.data.opcode),
    .in_key({in_ch.data.byte_7, in_ch.data.byte_6, in_ch.data.byte_5, in_ch.data.byte_4,
             in_ch.data.byte_3, in_ch.data.byte_2, in_ch.data.byte_1, in_ch.data.byte_0}),
    .q_valid, .q_ready, .q_opcode, .q_key, .q_home
  );

  htdt_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_opcode, .q_key, .q_home,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );
endmodule
`default_nettype wire
